// ===== sv/bellman_ford_shortest_paths_assert.svh =====
// assertion macros, clocked on clk and disabled while rst is high
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication
`define BFSP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bfsp_pkg.sv =====
package bfsp_pkg;

  // field widths of the channels
  localparam int COMMAND_W  = 1;
  localparam int EDGE_IDX_W = 8;
  localparam int VERTEX_W   = 5;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 32;
  localparam int VCOUNT_W   = 6;
  localparam int ECOUNT_W   = 9;

  // default sizes
  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_MAX_EDGES    = 256;
  localparam int DEF_WEIGHT_BITS  = 16;

  // apb
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic signed [DIST_W-1:0] INT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] INT_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(1);
  localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = '0;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_LOAD = 1'b0,
    CMD_RUN  = 1'b1
  } bfsp_cmd_t;

  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0,
    REG_EDGE_COUNT   = 1'b1
  } bfsp_reg_t;

endpackage

// ===== sv/bfsp_in_if.sv =====
interface bfsp_in_if;
  import bfsp_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [COMMAND_W-1:0]        command;
  logic [EDGE_IDX_W-1:0]       edge_index;
  logic [VERTEX_W-1:0]         edge_source;
  logic [VERTEX_W-1:0]         edge_dest;
  logic signed [WEIGHT_W-1:0]  edge_weight;
  logic [VERTEX_W-1:0]         source_vertex;

  modport source (
    output valid, command, edge_index, edge_source, edge_dest, edge_weight, source_vertex,
    input  ready
  );

  modport sink (
    input  valid, command, edge_index, edge_source, edge_dest, edge_weight, source_vertex,
    output ready
  );
endinterface

// ===== sv/bfsp_out_if.sv =====
interface bfsp_out_if;
  import bfsp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [VERTEX_W-1:0]        vertex;
  logic signed [DIST_W-1:0]   distance;
  logic                       reachable;
  logic                       negative_cycle;
  logic                       last;

  modport source (
    output valid, vertex, distance, reachable, negative_cycle, last,
    input  ready
  );

  modport sink (
    input  valid, vertex, distance, reachable, negative_cycle, last,
    output ready
  );
endinterface

// ===== sv/bellman_ford_shortest_paths.sv =====
// bellman-ford single-source shortest paths over a loaded edge list
//
// item channel: a load word (command load) writes one edge (tail, head, weight) into
// the edge memory at edge_index in the cycle it is taken; slots at or beyond
// MAX_EDGES are dropped. a run word (command run) starts a search from source_vertex.
// result channel: one word per vertex 0..nv-1, nv being vertex_count clamped to
// 1..MAX_VERTICES (last on the final one), or a single word with negative_cycle and last set.
// apb port: vertex_count at 0x0, edge_count at 0x4; write only while idle.
// timing: loads stream at one per cycle while the sequencer is idle. a run clears
// the distances of vertices 0..nv-1, then makes nv passes over the edges (nv-1
// relaxing and one checking). each edge in range goes through the registered edge
// memory read, then the registered distance memory read, then the single shared
// add/saturate/compare unit; an edge out of range skips that unit. then each result
// word is read and registered for output. item.ready is low for the whole run.
// a source outside the graph skips the passes; a negative cycle ends the checking
// pass at the offending edge and gives its single word.
// reset: vertex_count 1, edge_count 0, sequencer idle, no result pending; edge
// memory contents are undefined until loaded.
// stalls: results sit in an output register; the sequencer waits on a full one,
// and a new word is taken while the final result still waits to be taken
`include "bellman_ford_shortest_paths_assert.svh"

module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = bfsp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = bfsp_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = bfsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  bfsp_in_if.sink                      item,
  bfsp_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfsp_pkg::PADDR_W-1:0] paddr,
  input  logic [bfsp_pkg::PDATA_W-1:0] pwdata,
  output logic [bfsp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bfsp_pkg::*;

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * VERTEX_W + WEIGHT_BITS;
  localparam int DW  = DIST_W + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_EFETCH = 8'b0000_0100,
    S_EREAD  = 8'b0000_1000,
    S_ERELAX = 8'b0001_0000,
    S_NEG    = 8'b0010_0000,
    S_OREQ   = 8'b0100_0000,
    S_OLOAD  = 8'b1000_0000
  } state_t;

  state_t                   state;
  logic [VCOUNT_W-1:0]      vertex_count;
  logic [ECOUNT_W-1:0]      edge_count;
  logic [VERTEX_W-1:0]      src;
  logic [VCW-1:0]           vcnt;
  logic [VCW-1:0]           pass;
  logic [ECW-1:0]           eidx;

  // output register
  logic                     res_valid;
  logic [VERTEX_W-1:0]      res_vertex;
  logic signed [DIST_W-1:0] res_distance;
  logic                     res_reachable;
  logic                     res_negative;
  logic                     res_last;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  bfsp_reg_t cfg_idx;
  logic      cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = bfsp_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_VERTEX_COUNT: prdata = PDATA_W'(vertex_count);
      REG_EDGE_COUNT:   prdata = PDATA_W'(edge_count);
      default:          prdata = '0;
    endcase
  end

  // effective sizes, clamped to what the stores hold
  logic [VCW-1:0] nv_eff;
  logic [ECW-1:0] ne_eff;
  logic           src_ok;

  always_comb begin
    if (vertex_count == '0) begin
      nv_eff = VCW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      nv_eff = VCW'(MAX_VERTICES);
    end else begin
      nv_eff = VCW'(vertex_count);
    end
    if (32'(edge_count) > MAX_EDGES) begin
      ne_eff = ECW'(MAX_EDGES);
    end else begin
      ne_eff = ECW'(edge_count);
    end
  end

  assign src_ok = 32'(src) < 32'(nv_eff);

  // ---------------------------------------------------------------------------
  // edge memory: {tail, head, weight}
  // ---------------------------------------------------------------------------
  logic                    edge_we;
  logic signed [31:0]      w_ext;
  logic [EW-1:0]           edge_wdata;
  logic [EW-1:0]           edge_rdata;
  logic [VERTEX_W-1:0]     e_tail;
  logic [VERTEX_W-1:0]     e_head;
  logic signed [WEIGHT_BITS-1:0] e_weight;
  logic                    e_in_range;

  // weight wraps to WEIGHT_BITS, two's complement
  assign w_ext      = 32'(item.edge_weight);
  assign edge_wdata = {item.edge_source, item.edge_dest, w_ext[WEIGHT_BITS-1:0]};
  assign edge_we    = item.valid && item.ready && (item.command == CMD_LOAD)
                      && (32'(item.edge_index) < MAX_EDGES);

  bfsp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EAW'(item.edge_index)),
    .wdata (edge_wdata),
    .raddr (EAW'(eidx)),
    .rdata (edge_rdata)
  );

  assign e_tail     = edge_rdata[EW-1 -: VERTEX_W];
  assign e_head     = edge_rdata[WEIGHT_BITS +: VERTEX_W];
  assign e_weight   = edge_rdata[WEIGHT_BITS-1:0];
  assign e_in_range = (32'(e_tail) < 32'(nv_eff)) && (32'(e_head) < 32'(nv_eff));

  // ---------------------------------------------------------------------------
  // distance memory: {reachable, distance}, two copies so tail and head read together
  // ---------------------------------------------------------------------------
  logic           dist_we;
  logic [VAW-1:0] dist_waddr;
  logic [DW-1:0]  dist_wdata;
  logic [VAW-1:0] dist_raddr_a;
  logic [DW-1:0]  dist_rdata_a;
  logic [DW-1:0]  dist_rdata_b;

  assign dist_raddr_a = ((state == S_OREQ) || (state == S_OLOAD)) ? VAW'(vcnt)
                                                                   : VAW'(e_tail);

  bfsp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_a (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr_a),
    .rdata (dist_rdata_a)
  );

  bfsp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_b (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (VAW'(e_head)),
    .rdata (dist_rdata_b)
  );

  // ---------------------------------------------------------------------------
  // shared relax unit: saturating add then compare against the head distance
  // ---------------------------------------------------------------------------
  logic signed [DIST_W-1:0] du;
  logic signed [DIST_W-1:0] dv;
  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;
  logic                     better;
  logic                     checking;

  assign du  = dist_rdata_a[DIST_W-1:0];
  assign dv  = dist_rdata_b[DIST_W-1:0];
  assign sum = (DIST_W + 1)'(du) + (DIST_W + 1)'(e_weight);

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? INT_MIN : INT_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  // unreachable tail never relaxes; unreachable head takes any candidate from a reachable tail
  assign better   = dist_rdata_a[DIST_W] && (!dist_rdata_b[DIST_W] || (cand < dv));
  assign checking = (pass == nv_eff);

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = VAW'(e_head);
    dist_wdata = {1'b1, cand};
    case (state)
      S_CLEAR: begin
        // clear sweep also seeds the source at distance zero
        dist_we    = 1'b1;
        dist_waddr = VAW'(vcnt);
        dist_wdata = {(32'(vcnt) == 32'(src)), {DIST_W{1'b0}}};
      end
      S_ERELAX: begin
        dist_we = better && !checking;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic out_free;
  logic res_load;

  assign out_free   = !res_valid || result.ready;
  assign res_load   = ((state == S_NEG) || (state == S_OLOAD)) && out_free;
  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VCOUNT_RESET;
      edge_count   <= ECOUNT_RESET;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_VERTEX_COUNT: vertex_count <= pwdata[VCOUNT_W-1:0];
          REG_EDGE_COUNT:   edge_count   <= pwdata[ECOUNT_W-1:0];
          default: ;
        endcase
      end

      // a new word may replace the one taken in the same cycle
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item.valid && (item.command == CMD_RUN)) begin
            src   <= item.source_vertex;
            vcnt  <= '0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (vcnt == VCW'(nv_eff - 1'b1)) begin
            vcnt  <= '0;
            eidx  <= '0;
            pass  <= VCW'(1);
            state <= src_ok ? S_EFETCH : S_OREQ;
          end else begin
            vcnt <= vcnt + 1'b1;
          end
        end
        S_EFETCH: begin
          // end of a pass: nv-1 relaxing passes, then the checking pass
          if (eidx == ne_eff) begin
            eidx <= '0;
            if (checking) begin
              state <= S_OREQ;
            end else begin
              pass <= pass + 1'b1;
            end
          end else begin
            state <= S_EREAD;
          end
        end
        S_EREAD: begin
          if (e_in_range) begin
            state <= S_ERELAX;
          end else begin
            eidx  <= eidx + 1'b1;
            state <= S_EFETCH;
          end
        end
        S_ERELAX: begin
          if (better && checking) begin
            state <= S_NEG;
          end else begin
            eidx  <= eidx + 1'b1;
            state <= S_EFETCH;
          end
        end
        S_NEG: begin
          if (out_free) begin
            res_vertex    <= '0;
            res_distance  <= '0;
            res_reachable <= 1'b0;
            res_negative  <= 1'b1;
            res_last      <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_OREQ: begin
          state <= S_OLOAD;
        end
        S_OLOAD: begin
          if (out_free) begin
            res_vertex    <= VERTEX_W'(vcnt);
            res_distance  <= dist_rdata_a[DIST_W] ? du : INT_MAX;
            res_reachable <= dist_rdata_a[DIST_W];
            res_negative  <= 1'b0;
            res_last      <= (vcnt == VCW'(nv_eff - 1'b1));
            if (vcnt == VCW'(nv_eff - 1'b1)) begin
              state <= S_IDLE;
            end else begin
              vcnt  <= vcnt + 1'b1;
              state <= S_OREQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.vertex         = res_vertex;
  assign result.distance       = res_distance;
  assign result.reachable      = res_reachable;
  assign result.negative_cycle = res_negative;
  assign result.last           = res_last;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `BFSP_ASSERT_IMPLIES(a_dist_wr_phase, dist_we, (state == S_CLEAR) || ((state == S_ERELAX) && (pass != nv_eff)), "distance written outside clear or relaxing pass")
  `BFSP_ASSERT_IMPLIES(a_edge_in_use, state == S_EREAD, eidx < ne_eff, "edge read beyond edge_count")
  `BFSP_ASSERT_NEXT(a_neg_result, (state == S_NEG) && out_free, res_valid && res_negative && res_last && !res_reachable, "negative cycle word malformed")

endmodule

// ===== sv/bfsp_ram.sv =====
module bfsp_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
